>>> design/stk_pkg.sv
// Shared widths, reset values and types for the sparse row top-k selector.
package stk_pkg;

    localparam int unsigned ValueW = 32;
    localparam int unsigned ColW = 16;
    localparam int unsigned IdW = 17;
    localparam int unsigned RankW = 6;
    localparam int unsigned KW = 7;
    localparam int unsigned MaxKDefault = 64;
    localparam logic [KW-1:0] KReset = 7'd64;
    localparam logic signed [IdW-1:0] EndMarkerId = '1;

    typedef struct packed {
        logic                     valid;
        logic signed [ValueW-1:0] value;
        logic [ColW-1:0]          col;
    } t_entry;

    typedef struct packed {
        logic ins;
        logic shift;
        logic clear;
    } t_cell_ctl;

endpackage

>>> design/stk_in_if.sv
// Input channel carrying one sparse row entry per word.
interface stk_in_if;
    import stk_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [ValueW-1:0] entry_value;
    logic [ColW-1:0]          col_index;
    logic                     row_last;
    logic                     row_empty;

    modport source (output valid, entry_value, col_index, row_last, row_empty, input ready);
    modport sink (input valid, entry_value, col_index, row_last, row_empty, output ready);
endinterface

>>> design/stk_out_if.sv
// Output channel carrying one ranked result per word.
interface stk_out_if;
    import stk_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [IdW-1:0]    out_id;
    logic signed [ValueW-1:0] out_value;
    logic [RankW-1:0]         out_rank;
    logic                     last_of_row;

    modport source (output valid, out_id, out_value, out_rank, last_of_row, input ready);
    modport sink (input valid, out_id, out_value, out_rank, last_of_row, output ready);
endinterface

>>> design/stk_cell.sv
// One compare-and-shift cell of the sorted top-k chain.
module stk_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  stk_pkg::t_cell_ctl i_ctl,
    input  stk_pkg::t_entry    i_new,
    input  stk_pkg::t_entry    i_prev,
    input  logic               i_prev_gt,
    input  stk_pkg::t_entry    i_next,
    output stk_pkg::t_entry    o_entry,
    output logic               o_gt
);
    import stk_pkg::*;

    logic                     r_valid;
    logic signed [ValueW-1:0] r_value;
    logic [ColW-1:0]          r_col;
    logic                     n_valid;
    logic signed [ValueW-1:0] n_value;
    logic [ColW-1:0]          n_col;
    logic                     valid_eff;

    assign valid_eff = r_valid & i_en;
    assign o_gt = !valid_eff || (i_new.value > r_value);
    assign o_entry = '{valid: valid_eff, value: r_value, col: r_col};

    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        n_col = r_col;
        if (i_ctl.clear) begin
            n_valid = 1'b0;
        end else if (i_ctl.shift) begin
            n_valid = i_next.valid;
            n_value = i_next.value;
            n_col = i_next.col;
        end else if (i_ctl.ins) begin
            if (!i_en) begin
                n_valid = 1'b0;
            end else if (i_prev_gt) begin
                n_valid = i_prev.valid;
                n_value = i_prev.value;
                n_col = i_prev.col;
            end else if (o_gt) begin
                n_valid = 1'b1;
                n_value = i_new.value;
                n_col = i_new.col;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_value <= n_value;
        r_col <= n_col;
    end
endmodule

>>> design/sparse_row_top_k_select.sv
// Top level of the sparse row top-k selector: cell chain, drain control and output register.
//
//   channel | dir | handshake     | word
//   i_in    | in  | valid / ready | entry_value, col_index, row_last, row_empty
//   o_out   | out | valid / ready | out_id, out_value, out_rank, last_of_row
//   i_cfg   | in  | i_cfg_we      | k_count (7 bits)
//
// Entries of a row are taken one per cycle while no drain runs; the cell chain inserts each
// as it is taken. After a row's last word the chain drains through cell 0, one result
// per cycle unless the output stalls; input is held off until the drain has finished.
// Reset is synchronous and active low; it empties the chain and sets k_count to 64.
// A stalled output holds its word; the drain waits for the output register to free up.
module sparse_row_top_k_select #(
    parameter int unsigned MAX_K = stk_pkg::MaxKDefault
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    stk_in_if.sink                 i_in,
    stk_out_if.source              o_out,
    input  logic                   i_cfg_we,
    input  logic [stk_pkg::KW-1:0] i_cfg_data
);
    import stk_pkg::*;

    logic [KW-1:0]            r_k;
    logic [KW-1:0]            kk;
    logic                     r_emit;
    logic [KW-1:0]            r_rank;
    logic                     r_out_valid;
    logic signed [IdW-1:0]    r_out_id;
    logic signed [ValueW-1:0] r_out_value;
    logic [RankW-1:0]         r_out_rank;
    logic                     r_out_last;

    logic                     accept;
    logic                     row_end;
    logic                     emit_step;
    logic                     head_last;
    t_cell_ctl                ctl;
    t_entry                   new_entry;
    t_entry                   chain [MAX_K+1];
    logic                     gt [MAX_K];

    always_comb begin
        if (r_k == '0) begin
            kk = KW'(1);
        end else if (r_k > KW'(MAX_K)) begin
            kk = KW'(MAX_K);
        end else begin
            kk = r_k;
        end
    end

    assign i_in.ready = !r_emit;
    assign accept = i_in.valid && i_in.ready;
    assign row_end = i_in.row_last || i_in.row_empty;
    assign emit_step = r_emit && (!r_out_valid || o_out.ready);
    assign head_last = chain[0].valid ? (!chain[1].valid && ((r_rank + KW'(1)) == kk)) : 1'b1;

    assign new_entry = '{valid: 1'b1, value: i_in.entry_value, col: i_in.col_index};

    assign ctl.ins = accept && !i_in.row_empty;
    assign ctl.shift = emit_step && chain[0].valid;
    assign ctl.clear = emit_step && head_last;

    assign chain[MAX_K] = '{valid: 1'b0, value: '0, col: '0};

    for (genvar i = 0; i < MAX_K; i++) begin : g_cell
        stk_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (KW'(i) < kk),
            .i_ctl     (ctl),
            .i_new     (new_entry),
            .i_prev    ((i == 0) ? chain[MAX_K] : chain[(i == 0) ? 0 : i-1]),
            .i_prev_gt ((i == 0) ? 1'b0 : gt[(i == 0) ? 0 : i-1]),
            .i_next    (chain[i+1]),
            .o_entry   (chain[i]),
            .o_gt      (gt[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= KReset;
            r_emit <= 1'b0;
            r_rank <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_k <= i_cfg_data;
            end
            if (accept && row_end) begin
                r_emit <= 1'b1;
                r_rank <= '0;
            end else if (emit_step) begin
                r_rank <= r_rank + KW'(1);
                if (head_last) begin
                    r_emit <= 1'b0;
                end
            end
            if (emit_step) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (emit_step) begin
            r_out_rank <= r_rank[RankW-1:0];
            r_out_last <= head_last;
            if (chain[0].valid) begin
                r_out_id <= {1'b0, chain[0].col};
                r_out_value <= chain[0].value;
            end else begin
                r_out_id <= EndMarkerId;
                r_out_value <= '0;
            end
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.out_id = r_out_id;
    assign o_out.out_value = r_out_value;
    assign o_out.out_rank = r_out_rank;
    assign o_out.last_of_row = r_out_last;

    a_row_end_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && row_end) |=> r_emit)
        else $error("row end did not start the drain");

    a_marker_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_id == EndMarkerId)) |-> r_out_last)
        else $error("end marker not flagged as last of row");

    a_empty_head_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_step && !chain[0].valid) |=> (!r_emit && r_out_last))
        else $error("drain continued past the end marker");

    a_chain_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (MAX_K > 1 && chain[1].valid) |-> (chain[0].valid && chain[0].value >= chain[1].value))
        else $error("head cells out of order");
endmodule
